### hdl/ultrasonic_range_controller_defines.svh
// Assertion helpers shared by the RTL of the ultrasonic range controller.
// Every macro samples on clk and is disabled while rst_n is low, so it is
// used only inside modules that have those two ports.
`ifndef ULTRASONIC_RANGE_CONTROLLER_DEFINES_SVH
`define ULTRASONIC_RANGE_CONTROLLER_DEFINES_SVH

// Same-cycle implication.
`define URC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Implication checked on the following clock.
`define URC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/urc_pkg.sv
`timescale 1ns / 1ps

package urc_pkg;

  // Counter width default and the width used for mixed-width compares.
  localparam int COUNT_BITS_DEF = 24;
  localparam int CMP_W          = 32;

  // Register and field widths.
  localparam int TRIG_W     = 16;
  localparam int TMO_W      = 24;
  localparam int SPEED_W    = 20;
  localparam int MM_W       = 16;
  localparam int CM_W       = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Register reset values.
  localparam logic [TRIG_W-1:0]  TRIG_PULSE_RST = 16'd10;
  localparam logic [TMO_W-1:0]   ECHO_TMO_RST   = 24'd30000;
  localparam logic [SPEED_W-1:0] SPEED_RST      = 20'd34300;
  localparam logic [MM_W-1:0]    RANGE_MIN_RST  = 16'd20;
  localparam logic [MM_W-1:0]    RANGE_MAX_RST  = 16'd4000;

  // Ticks the trigger is held low before the pulse.
  localparam int PRELOW_TICKS = 2;

  // width*speed/200000 is done as ((p >> 6) / 3125), the division by 3125
  // as a multiply by floor(2^40/3125) followed by one correction step.
  localparam int MM_SHIFT    = 6;
  localparam int MM_ODD      = 3125;
  localparam int RECIP_SHIFT = 40;
  localparam int RECIP_W     = 29;
  localparam int X_W         = 28;
  localparam int QP_W        = X_W + RECIP_W;
  localparam logic [RECIP_W-1:0] MM_RECIP = 29'd351843720;

  // Smallest product that gives a distance above the 16-bit maximum.
  localparam logic [63:0]     SAT_LIMIT = 64'd13107200000;
  localparam logic [MM_W-1:0] MM_MAX    = 16'hFFFF;

  // mm / 10 as (mm * 52429) >> 19, exact over the whole 16-bit range.
  localparam int CM_PROD_W = 32;
  localparam int CM_SHIFT  = 19;
  localparam logic [MM_W-1:0] CM_RECIP = 16'd52429;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_PRELOW,
    PH_TRIG,
    PH_RISE,
    PH_WIDTH
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_TIMEOUT = 2'd1,
    ST_RANGE   = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRIG_PULSE = 3'd0,
    CFG_ECHO_TMO   = 3'd1,
    CFG_SPEED      = 3'd2,
    CFG_RANGE_MIN  = 3'd3,
    CFG_RANGE_MAX  = 3'd4
  } cfg_idx_t;

  // Per-item flags produced by the sequencer.
  typedef struct packed {
    logic trigger;
    logic busy;
    logic done;
    logic fin_width;
  } seq_flags_t;

  typedef struct packed {
    logic [TMO_W-1:0]  echo_timeout;
    logic [TRIG_W-1:0] trigger_pulse;
  } seq_cfg_t;

  typedef struct packed {
    logic [SPEED_W-1:0] speed;
    logic [MM_W-1:0]    range_min;
    logic [MM_W-1:0]    range_max;
  } conv_cfg_t;

  // Item leaving the conversion pipeline.
  typedef struct packed {
    seq_flags_t      flags;
    status_t         status;
    logic [MM_W-1:0] mm;
  } conv_res_t;

endpackage

### hdl/urc_in_if.sv
`timescale 1ns / 1ps

interface urc_in_if;
  logic valid;
  logic ready;
  logic cmd;
  logic echo_level;

  modport source (output valid, output cmd, output echo_level, input ready);
  modport sink (input valid, input cmd, input echo_level, output ready);
endinterface

### hdl/urc_out_if.sv
`timescale 1ns / 1ps

interface urc_out_if;
  logic                        valid;
  logic                        ready;
  logic                        trigger_level;
  logic                        busy_res;
  logic                        done_res;
  logic [1:0]                  result_status;
  logic [urc_pkg::MM_W-1:0]    meas_mm;
  logic [urc_pkg::CM_W-1:0]    meas_cm;

  modport source (
    output valid, output trigger_level, output busy_res, output done_res,
    output result_status, output meas_mm, output meas_cm,
    input ready
  );
  modport sink (
    input valid, input trigger_level, input busy_res, input done_res,
    input result_status, input meas_mm, input meas_cm,
    output ready
  );
endinterface

### hdl/urc_cfg_if.sv
`timescale 1ns / 1ps

interface urc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [urc_pkg::CFG_IDX_W-1:0]   index;
  logic [urc_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### hdl/urc_seq.sv
`timescale 1ns / 1ps
`include "ultrasonic_range_controller_defines.svh"

// Measurement sequencer: advances phase and tick counter on every accepted
// transaction and registers the item's flags and the finished echo width.
module urc_seq #(
  parameter int COUNT_BITS = urc_pkg::COUNT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   cmd,
  input  logic                   echo_level,
  input  urc_pkg::seq_cfg_t      cfg,
  output logic                   v_o,
  output urc_pkg::seq_flags_t    flags_o,
  output logic [COUNT_BITS-1:0]  width_o,
  input  logic                   rdy_i
);

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  urc_pkg::phase_t       phase_r, phase_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic [urc_pkg::CMP_W-1:0] cnt_inc_x;
  logic                  expired_inc, expired_one;
  logic                  acc;
  logic                  v_r;
  urc_pkg::seq_flags_t   flags_r, flags_nxt;
  logic [COUNT_BITS-1:0] width_r;

  assign in_ready = !v_r || rdy_i;
  assign acc      = in_valid && in_ready;

  assign cnt_inc     = (cnt_r == CNT_MAX) ? CNT_MAX : cnt_r + 1'b1;
  assign cnt_inc_x   = urc_pkg::CMP_W'(cnt_inc);
  assign expired_inc = (cnt_inc_x >= urc_pkg::CMP_W'(cfg.echo_timeout)) ||
                       (cnt_inc == CNT_MAX);
  assign expired_one = cfg.echo_timeout <= urc_pkg::TMO_W'(1);

  always_comb begin
    phase_nxt           = phase_r;
    cnt_nxt             = cnt_r;
    flags_nxt.done      = 1'b0;
    flags_nxt.fin_width = 1'b0;
    if (cmd) begin
      if (phase_r == urc_pkg::PH_IDLE) begin
        phase_nxt = urc_pkg::PH_PRELOW;
        cnt_nxt   = '0;
      end
    end else begin
      unique case (phase_r)
        urc_pkg::PH_PRELOW: begin
          cnt_nxt = cnt_inc;
          if (cnt_inc_x >= urc_pkg::CMP_W'(urc_pkg::PRELOW_TICKS)) begin
            phase_nxt = urc_pkg::PH_TRIG;
            cnt_nxt   = '0;
          end
        end
        urc_pkg::PH_TRIG: begin
          cnt_nxt = cnt_inc;
          if (cnt_inc_x >= urc_pkg::CMP_W'(cfg.trigger_pulse)) begin
            phase_nxt = urc_pkg::PH_RISE;
            cnt_nxt   = '0;
          end
        end
        urc_pkg::PH_RISE: begin
          if (echo_level) begin
            phase_nxt = urc_pkg::PH_WIDTH;
            cnt_nxt   = COUNT_BITS'(1);
            if (expired_one) begin
              phase_nxt      = urc_pkg::PH_IDLE;
              cnt_nxt        = '0;
              flags_nxt.done = 1'b1;
            end
          end else begin
            cnt_nxt = cnt_inc;
            if (expired_inc) begin
              phase_nxt      = urc_pkg::PH_IDLE;
              cnt_nxt        = '0;
              flags_nxt.done = 1'b1;
            end
          end
        end
        urc_pkg::PH_WIDTH: begin
          if (!echo_level) begin
            phase_nxt           = urc_pkg::PH_IDLE;
            cnt_nxt             = '0;
            flags_nxt.done      = 1'b1;
            flags_nxt.fin_width = 1'b1;
          end else begin
            cnt_nxt = cnt_inc;
            if (expired_inc) begin
              phase_nxt      = urc_pkg::PH_IDLE;
              cnt_nxt        = '0;
              flags_nxt.done = 1'b1;
            end
          end
        end
        default: begin
          phase_nxt = urc_pkg::PH_IDLE;
          cnt_nxt   = '0;
        end
      endcase
    end
    flags_nxt.trigger = (phase_nxt == urc_pkg::PH_TRIG);
    flags_nxt.busy    = (phase_nxt != urc_pkg::PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= urc_pkg::PH_IDLE;
      cnt_r   <= '0;
    end else if (acc) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  // The width is the count before the closing tick.
  always_ff @(posedge clk) begin
    if (acc) begin
      flags_r <= flags_nxt;
      width_r <= cnt_r;
    end
  end

  assign v_o     = v_r;
  assign flags_o = flags_r;
  assign width_o = width_r;

  `URC_ASSERT_IMP(a_idle_count_clear, phase_r == urc_pkg::PH_IDLE, cnt_r == '0, "idle with nonzero tick count")
  `URC_ASSERT_NEXT(a_start_enters_prelow, acc && cmd && phase_r == urc_pkg::PH_IDLE, phase_r == urc_pkg::PH_PRELOW, "start did not begin a measurement")
  `URC_ASSERT_IMP(a_done_ends_busy, acc && flags_nxt.done, phase_r != urc_pkg::PH_IDLE && !flags_nxt.busy, "done outside a running measurement")

endmodule

### hdl/urc_conv.sv
`timescale 1ns / 1ps

// Three-stage width to distance pipeline: product, reciprocal multiply,
// quotient correction with saturation and range check.
module urc_conv #(
  parameter int COUNT_BITS = urc_pkg::COUNT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   v_i,
  output logic                   rdy_o,
  input  urc_pkg::seq_flags_t    flags_i,
  input  logic [COUNT_BITS-1:0]  width_i,
  input  urc_pkg::conv_cfg_t     cfg,
  output logic                   v_o,
  output urc_pkg::conv_res_t     res_o,
  input  logic                   rdy_i
);

  localparam int PW = COUNT_BITS + urc_pkg::SPEED_W;
  localparam logic [PW-1:0] SAT_LIM = PW'(urc_pkg::SAT_LIMIT);

  logic rdy2, rdy3, rdy4;

  // Stage 2: width times speed.
  logic                 v2_r;
  urc_pkg::seq_flags_t  flags2_r;
  logic [PW-1:0]        prod2_r;

  // Stage 3: divide the product by 64, then multiply by the reciprocal of 3125.
  logic                     v3_r;
  urc_pkg::seq_flags_t      flags3_r;
  logic                     sat3_r;
  logic [urc_pkg::X_W-1:0]  x3_r;
  logic [urc_pkg::QP_W-1:0] qp3_r;
  logic [urc_pkg::X_W-1:0]  x3_nxt;

  // Stage 4: correct the estimate and check the range.
  logic                     v4_r;
  urc_pkg::conv_res_t       res4_r, res4_nxt;
  logic [urc_pkg::MM_W-1:0] q_est, q_fix, mm;
  logic [urc_pkg::X_W-1:0]  back, rem;

  assign rdy2  = !v2_r || rdy3;
  assign rdy3  = !v3_r || rdy4;
  assign rdy4  = !v4_r || rdy_i;
  assign rdy_o = rdy2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy2) v2_r <= v_i;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (v_i && rdy2) begin
      flags2_r <= flags_i;
      prod2_r  <= PW'(width_i) * PW'(cfg.speed);
    end
  end

  assign x3_nxt = prod2_r[urc_pkg::MM_SHIFT +: urc_pkg::X_W];

  always_ff @(posedge clk) begin
    if (v2_r && rdy3) begin
      flags3_r <= flags2_r;
      sat3_r   <= prod2_r >= SAT_LIM;
      x3_r     <= x3_nxt;
      qp3_r    <= urc_pkg::QP_W'(x3_nxt) * urc_pkg::QP_W'(urc_pkg::MM_RECIP);
    end
  end

  // The estimate is the true quotient or one below it.
  assign q_est = qp3_r[urc_pkg::RECIP_SHIFT +: urc_pkg::MM_W];
  assign back  = urc_pkg::X_W'(q_est) * urc_pkg::X_W'(urc_pkg::MM_ODD);
  assign rem   = x3_r - back;
  assign q_fix = q_est + urc_pkg::MM_W'(rem >= urc_pkg::X_W'(urc_pkg::MM_ODD));
  assign mm    = sat3_r ? urc_pkg::MM_MAX : q_fix;

  always_comb begin
    res4_nxt.flags = flags3_r;
    if (!flags3_r.fin_width) begin
      res4_nxt.status = urc_pkg::ST_TIMEOUT;
      res4_nxt.mm     = '0;
    end else if (mm < cfg.range_min || mm > cfg.range_max) begin
      res4_nxt.status = urc_pkg::ST_RANGE;
      res4_nxt.mm     = '0;
    end else begin
      res4_nxt.status = urc_pkg::ST_OK;
      res4_nxt.mm     = mm;
    end
  end

  always_ff @(posedge clk) begin
    if (v3_r && rdy4) begin
      res4_r <= res4_nxt;
    end
  end

  assign v_o   = v4_r;
  assign res_o = res4_r;

endmodule

### hdl/ultrasonic_range_controller.sv
// Ultrasonic range controller for an HC-SR04 style sensor. Every input
// transaction is either a start command or one microsecond tick carrying the
// sampled echo pin level, and every input transaction yields exactly one
// result transaction, in order, giving the trigger pin level, the busy flag,
// a done flag on the item that ends a measurement, and the status and
// distance of the latest finished measurement in millimetres and
// centimetres. The block takes one transaction per clock while the sink takes
// results: the sequencer updates its phase and tick counter in the cycle an
// item is accepted, and the width to distance conversion runs as a pipeline
// behind it, so each result passes the sequencer register, the conversion
// stages and the output register; these stages keep taking items while a
// result waits at the output, until they are full. Configuration registers
// are written through the cfg port, which is always ready; writes should be
// made while no measurement is running and no result is still in flight.
`timescale 1ns / 1ps

module ultrasonic_range_controller #(
  parameter int COUNT_BITS = urc_pkg::COUNT_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  urc_in_if.sink     in_if,
  urc_out_if.source  out_if,
  urc_cfg_if.sink    cfg_if
);

  // Configuration registers.
  logic [urc_pkg::TRIG_W-1:0]  trig_pulse_r;
  logic [urc_pkg::TMO_W-1:0]   echo_tmo_r;
  logic [urc_pkg::SPEED_W-1:0] speed_r;
  logic [urc_pkg::MM_W-1:0]    range_min_r;
  logic [urc_pkg::MM_W-1:0]    range_max_r;

  urc_pkg::seq_cfg_t  seq_cfg;
  urc_pkg::conv_cfg_t conv_cfg;

  logic                  seq_v, seq_rdy;
  urc_pkg::seq_flags_t   seq_flags;
  logic [COUNT_BITS-1:0] seq_width;

  logic               conv_v, conv_rdy;
  urc_pkg::conv_res_t conv_res;

  // Output stage and the remembered result of the last measurement.
  logic                     out_v_r;
  urc_pkg::seq_flags_t      out_flags_r;
  urc_pkg::status_t         out_status_r, last_status_r, status_sel;
  logic [urc_pkg::MM_W-1:0] out_mm_r, last_mm_r, mm_sel;
  logic [urc_pkg::CM_W-1:0] out_cm_r, cm_sel;
  logic [urc_pkg::CM_PROD_W-1:0] cm_prod;

  // The configuration port never stalls.
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_pulse_r <= urc_pkg::TRIG_PULSE_RST;
      echo_tmo_r   <= urc_pkg::ECHO_TMO_RST;
      speed_r      <= urc_pkg::SPEED_RST;
      range_min_r  <= urc_pkg::RANGE_MIN_RST;
      range_max_r  <= urc_pkg::RANGE_MAX_RST;
    end else if (cfg_if.valid) begin
      // Indexes beyond the register list are dropped.
      unique case (urc_pkg::cfg_idx_t'(cfg_if.index))
        urc_pkg::CFG_TRIG_PULSE: trig_pulse_r <= cfg_if.data[urc_pkg::TRIG_W-1:0];
        urc_pkg::CFG_ECHO_TMO:   echo_tmo_r   <= cfg_if.data[urc_pkg::TMO_W-1:0];
        urc_pkg::CFG_SPEED:      speed_r      <= cfg_if.data[urc_pkg::SPEED_W-1:0];
        urc_pkg::CFG_RANGE_MIN:  range_min_r  <= cfg_if.data[urc_pkg::MM_W-1:0];
        urc_pkg::CFG_RANGE_MAX:  range_max_r  <= cfg_if.data[urc_pkg::MM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign seq_cfg.echo_timeout  = echo_tmo_r;
  assign seq_cfg.trigger_pulse = trig_pulse_r;
  assign conv_cfg.speed        = speed_r;
  assign conv_cfg.range_min    = range_min_r;
  assign conv_cfg.range_max    = range_max_r;

  // Phase and tick counting; the first pipeline register sits inside.
  urc_seq #(
    .COUNT_BITS (COUNT_BITS)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_if.valid),
    .in_ready   (in_if.ready),
    .cmd        (in_if.cmd),
    .echo_level (in_if.echo_level),
    .cfg        (seq_cfg),
    .v_o        (seq_v),
    .flags_o    (seq_flags),
    .width_o    (seq_width),
    .rdy_i      (seq_rdy)
  );

  // Echo width to millimetres, saturation and range check.
  urc_conv #(
    .COUNT_BITS (COUNT_BITS)
  ) u_conv (
    .clk     (clk),
    .rst_n   (rst_n),
    .v_i     (seq_v),
    .rdy_o   (seq_rdy),
    .flags_i (seq_flags),
    .width_i (seq_width),
    .cfg     (conv_cfg),
    .v_o     (conv_v),
    .res_o   (conv_res),
    .rdy_i   (conv_rdy)
  );

  // A finishing item replaces the remembered result; any other item repeats
  // it. Error results carry a zero distance, so the remembered distance is
  // cleared by them as well.
  assign status_sel = conv_res.flags.done ? conv_res.status : last_status_r;
  assign mm_sel     = conv_res.flags.done ? conv_res.mm : last_mm_r;
  assign cm_prod    = urc_pkg::CM_PROD_W'(mm_sel) * urc_pkg::CM_PROD_W'(urc_pkg::CM_RECIP);
  assign cm_sel     = cm_prod[urc_pkg::CM_SHIFT +: urc_pkg::CM_W];

  // The output register holds a result until the sink takes it, while the
  // stages behind it keep filling.
  assign conv_rdy = !out_v_r || out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r       <= 1'b0;
      last_status_r <= urc_pkg::ST_OK;
      last_mm_r     <= '0;
    end else if (conv_rdy) begin
      out_v_r <= conv_v;
      if (conv_v) begin
        last_status_r <= status_sel;
        last_mm_r     <= mm_sel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (conv_v && conv_rdy) begin
      out_flags_r  <= conv_res.flags;
      out_status_r <= status_sel;
      out_mm_r     <= mm_sel;
      out_cm_r     <= cm_sel;
    end
  end

  assign out_if.valid         = out_v_r;
  assign out_if.trigger_level = out_flags_r.trigger;
  assign out_if.busy_res      = out_flags_r.busy;
  assign out_if.done_res      = out_flags_r.done;
  assign out_if.result_status = out_status_r;
  assign out_if.meas_mm       = out_mm_r;
  assign out_if.meas_cm       = out_cm_r;

endmodule
